FILE: design/utcl_pkg.sv
`default_nettype none
package utcl_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned BACK_STAGES = 9;

	localparam logic [2:0] REG_ZONE_OFFSET  = 3'd0;
	localparam logic [2:0] REG_DST_ENABLED  = 3'd1;
	localparam logic [2:0] REG_BEGIN_MONTH  = 3'd2;
	localparam logic [2:0] REG_BEGIN_INDEX  = 3'd3;
	localparam logic [2:0] REG_BEGIN_HOUR   = 3'd4;
	localparam logic [2:0] REG_END_MONTH    = 3'd5;
	localparam logic [2:0] REG_END_INDEX    = 3'd6;
	localparam logic [2:0] REG_END_HOUR     = 3'd7;

	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_DAY  = SECS_PER_HOUR * 24;
	localparam int DAYS_PER_WEEK = 7;
	localparam int MONTHS        = 12;

	typedef struct packed {
		logic               action;
		logic signed [35:0] g;
		logic signed [35:0] base;
	} item_t;

	// a / 100 for a below 1024
	function automatic logic [3:0] div100(input logic [9:0] a);
		logic [20:0] p;
		p = 21'(a) * 21'd1311;
		return p[20:17];
	endfunction

	// a / 400 for a below 1024
	function automatic logic [1:0] div400(input logic [9:0] a);
		logic [15:0] p;
		p = 16'(a) * 16'd41;
		return p[15:14];
	endfunction

	// days from 1970-01-01 to january 1 of year y (1969..2600)
	function automatic logic signed [19:0] days_jan1(input logic [11:0] y);
		logic [11:0]        aw;
		logic [9:0]         a;
		logic signed [19:0] dy;
		aw = y - 12'd1601;
		a  = aw[9:0];
		dy = $signed({8'd0, y}) - 20'sd1970;
		return dy * 20'sd365 + $signed({12'd0, a[9:2]}) - $signed({16'd0, div100(a)})
			+ $signed({18'd0, div400(a)}) - 20'sd89;
	endfunction

	function automatic logic is_leap(input logic [11:0] y);
		logic [11:0] bw;
		logic [9:0]  b;
		logic [9:0]  bm1;
		logic        by100;
		logic        by400;
		bw    = y - 12'd1600;
		b     = bw[9:0];
		bm1   = b - 10'd1;
		by100 = div100(b) != div100(bm1);
		by400 = div400(b) != div400(bm1);
		return (b[1:0] == 2'd0) && (!by100 || by400);
	endfunction

	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/utcl_front.sv
`default_nettype none
module utcl_front (
	input  wire logic                 action,
	input  wire logic [33:0]          seconds_in,
	input  wire logic signed [4:0]    zone_offset_hours,
	output      utcl_pkg::item_t      item
);
	import utcl_pkg::*;

	logic signed [17:0] off_secs;
	logic signed [36:0] s_ext;
	logic signed [36:0] g_wide;
	logic signed [36:0] loc_wide;

	// offset in seconds, then the instant to test and the base result
	assign off_secs = 18'(zone_offset_hours) * 18'sd3600;
	assign s_ext    = $signed({3'd0, seconds_in});
	assign g_wide   = s_ext - 37'(off_secs);
	assign loc_wide = s_ext + 37'(off_secs);

	assign item.action = action;
	assign item.g      = action ? g_wide[35:0] : s_ext[35:0];
	assign item.base   = action ? g_wide[35:0] : loc_wide[35:0];

endmodule
`default_nettype wire

FILE: design/utcl_fifo.sv
`default_nettype none
module utcl_fifo #(
	parameter int unsigned Depth = utcl_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire utcl_pkg::item_t wr_data,
	output      logic            full,
	input  wire logic            rd_en,
	output      logic            empty,
	output      utcl_pkg::item_t rd_data
);
	import utcl_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	item_t            mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full    = count_q == CntW'(Depth);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth)) else $error("queue count overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty) else $error("queue read while empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("queue written while full");

endmodule
`default_nettype wire

FILE: design/utcl_year.sv
`default_nettype none
module utcl_year (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [35:0] g,
	output      logic [11:0]        year_s5
);
	import utcl_pkg::*;

	// floor(x / 675) for x below 2**28
	localparam logic [28:0] RECIP675 = 29'd407226529;

	logic [34:0]        gp;
	logic [56:0]        prod_s1;
	logic signed [19:0] d_s2;
	logic signed [32:0] m3_s3;
	logic signed [19:0] d_s3;
	logic signed [19:0] d_s4;
	logic [11:0]        est_s4;
	logic signed [19:0] dj_s4;
	logic signed [19:0] dj1_s4;
	logic signed [12:0] est_w;
	logic [11:0]        est;
	logic [18:0]        q1;

	// shift the instant up by one day so it is positive, /86400 = >>7 then /675
	assign gp    = 35'(g + 36'sd86400);
	assign q1    = prod_s1[56:38];
	assign est_w = 13'sd1970 + m3_s3[32:20];
	assign est   = est_w[11:0];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 57'(gp[34:7]) * 57'(RECIP675);
			d_s2    <= $signed({1'b0, q1}) - 20'sd1;
			m3_s3   <= 33'(d_s2) * 33'sd2871;
			d_s3    <= d_s2;
			est_s4  <= est;
			d_s4    <= d_s3;
			dj_s4   <= days_jan1(est);
			dj1_s4  <= days_jan1(est + 12'd1);
			if (d_s4 < dj_s4) begin
				year_s5 <= est_s4 - 12'd1;
			end else if (d_s4 >= dj1_s4) begin
				year_s5 <= est_s4 + 12'd1;
			end else begin
				year_s5 <= est_s4;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/utcl_edge.sv
`default_nettype none
module utcl_edge (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [11:0]       year,
	input  wire logic [3:0]        month,
	input  wire logic signed [3:0] week_index,
	input  wire logic [4:0]        hour,
	output      logic signed [37:0] edge_s4
);
	import utcl_pkg::*;

	localparam logic [18:0] RECIP7 = 19'd299594;

	logic               idx_pos;
	logic [4:0]         mp;
	logic               roll;
	logic [4:0]         mw;
	logic [3:0]         m;
	logic [11:0]        y2;
	logic signed [19:0] ms;
	logic signed [19:0] ms_s1;
	logic signed [19:0] dayt;
	logic [17:0]        v2;
	logic [36:0]        prod_s2;
	logic signed [19:0] dayt_s2;
	logic [17:0]        v3;
	logic [15:0]        q7;
	logic [17:0]        rem;
	logic [2:0]         wd;
	logic [2:0]         shift;
	logic signed [3:0]  weeks;
	logic signed [19:0] eday_s3;
	logic signed [19:0] vw2;
	logic signed [19:0] vw3;

	// positive index counts from the month, otherwise back from next month
	assign idx_pos = !week_index[3] && (week_index != 4'sd0);
	assign mp      = idx_pos ? {1'b0, month} : {1'b0, month} + 5'd1;
	assign roll    = mp >= 5'd12;
	assign mw      = roll ? mp - 5'd12 : mp;
	assign m       = mw[3:0];
	assign y2      = year + {11'd0, roll};
	assign ms      = days_jan1(y2) + $signed({11'd0, cum_days(m)})
		+ $signed({19'd0, is_leap(y2) && (m >= 4'd2)});

	// weekday of the day holding the hour, 0 is sunday
	assign dayt  = ms_s1 + $signed({19'd0, hour >= 5'd24});
	assign vw2   = dayt + 20'sd375;
	assign v2    = vw2[17:0];
	assign vw3   = dayt_s2 + 20'sd375;
	assign v3    = vw3[17:0];
	assign q7    = prod_s2[36:21];
	assign rem   = v3 - ((18'(q7) << 3) - 18'(q7));
	assign wd    = rem[2:0];
	assign shift = (wd == 3'd0) ? 3'd0 : 3'd7 - wd;
	assign weeks = idx_pos ? week_index - 4'sd1 : week_index;

	// the hour term below already carries the day spill of hours past 23
	always_ff @(posedge clk) begin
		if (en) begin
			ms_s1   <= ms;
			prod_s2 <= 37'(v2) * 37'(RECIP7);
			dayt_s2 <= dayt;
			eday_s3 <= dayt_s2 - $signed({19'd0, hour >= 5'd24})
				+ $signed({17'd0, shift}) + 20'(weeks) * 20'sd7;
			edge_s4 <= 38'(eday_s3) * 38'sd86400 + $signed({21'd0, 17'(hour) * 17'd3600});
		end
	end

endmodule
`default_nettype wire

FILE: design/utc_local_time_with_dst_top.sv
`default_nettype none
// utc / local epoch-second converter with an nth-sunday daylight-saving rule
//
// input channel: in_valid / in_ready carry action and seconds_in; action 0
// turns utc seconds into local time, action 1 turns local seconds into utc
// output channel: out_valid / out_ready carry seconds_out, in_dst and
// dst_observed, one result item for every input item, in order
// config: cfg_we, cfg_index, cfg_wdata write one register per cycle; write
// only while no item is in flight
//
// a result item passes from the queue through nine back stages into the
// output register; throughput is one item per cycle while the receiver
// takes results, set by the pipelined year and edge datapath
// the front classifies items into a small queue; the back pipeline advances
// as a whole whenever the output register is free or being taken
// when the receiver stalls, the back holds, the queue fills and in_ready drops
// reset clears the queue, the stage valid bits and the output valid bit, and
// loads the default registers (offset +8 hours, daylight saving off)
module utc_local_time_with_dst_top #(
	parameter int unsigned QueueDepth = utcl_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic               action,
	input  wire logic [33:0]        seconds_in,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic signed [35:0] seconds_out,
	output      logic               in_dst,
	output      logic               dst_observed,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [4:0]         cfg_wdata
);
	import utcl_pkg::*;

	localparam int unsigned NStg = BACK_STAGES;

	// configuration registers
	logic signed [4:0] zone_offset_q;
	logic              dst_enabled_q;
	logic [3:0]        begin_month_q;
	logic signed [3:0] begin_index_q;
	logic [4:0]        begin_hour_q;
	logic [3:0]        end_month_q;
	logic signed [3:0] end_index_q;
	logic [4:0]        end_hour_q;

	item_t              front_item;
	item_t              head;
	logic               q_full;
	logic               q_empty;
	logic               push;
	logic               pop;
	logic               en;

	logic [NStg-1:0]    vld_q;
	logic               act_q  [NStg];
	logic signed [35:0] g_q    [NStg];
	logic signed [35:0] base_q [NStg];

	logic [11:0]        year_s5;
	logic signed [37:0] begin_edge;
	logic signed [37:0] end_edge;
	logic signed [37:0] gt;
	logic               b_after_e;
	logic signed [37:0] lo;
	logic signed [37:0] hi;
	logic               dst;
	logic signed [35:0] res;

	logic               out_valid_q;
	logic signed [35:0] out_secs_q;
	logic               out_dst_q;
	logic               out_obs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_offset_q <= 5'sd8;
			dst_enabled_q <= 1'b0;
			begin_month_q <= '0;
			begin_index_q <= '0;
			begin_hour_q  <= '0;
			end_month_q   <= '0;
			end_index_q   <= '0;
			end_hour_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZONE_OFFSET: zone_offset_q <= cfg_wdata;
				REG_DST_ENABLED: dst_enabled_q <= cfg_wdata[0];
				REG_BEGIN_MONTH: begin_month_q <= cfg_wdata[3:0];
				REG_BEGIN_INDEX: begin_index_q <= cfg_wdata[3:0];
				REG_BEGIN_HOUR:  begin_hour_q  <= cfg_wdata;
				REG_END_MONTH:   end_month_q   <= cfg_wdata[3:0];
				REG_END_INDEX:   end_index_q   <= cfg_wdata[3:0];
				REG_END_HOUR:    end_hour_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: classify and queue
	utcl_front u_front (
		.action            (action),
		.seconds_in        (seconds_in),
		.zone_offset_hours (zone_offset_q),
		.item              (front_item)
	);

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// back advances as one pipeline when the output register can move
	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_empty;

	utcl_fifo #(.Depth(QueueDepth)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_item),
		.full    (q_full),
		.rd_en   (pop),
		.empty   (q_empty),
		.rd_data (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NStg-2:0], pop};
		end
	end

	// item fields ride alongside the datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			act_q[0]  <= head.action;
			g_q[0]    <= head.g;
			base_q[0] <= head.base;
			for (int i = 1; i < NStg; i++) begin
				act_q[i]  <= act_q[i-1];
				g_q[i]    <= g_q[i-1];
				base_q[i] <= base_q[i-1];
			end
		end
	end

	// year of the tested instant, stages one to five
	utcl_year u_year (
		.clk     (clk),
		.en      (en),
		.g       (head.g),
		.year_s5 (year_s5)
	);

	// begin and end instants in that year, stages six to nine
	utcl_edge u_edge_begin (
		.clk          (clk),
		.en           (en),
		.year         (year_s5),
		.month        (begin_month_q),
		.week_index   (begin_index_q),
		.hour         (begin_hour_q),
		.edge_s4      (begin_edge)
	);

	utcl_edge u_edge_end (
		.clk          (clk),
		.en           (en),
		.year         (year_s5),
		.month        (end_month_q),
		.week_index   (end_index_q),
		.hour         (end_hour_q),
		.edge_s4      (end_edge)
	);

	// inclusive window test, inverted when begin falls after end
	assign gt        = 38'(g_q[NStg-1]);
	assign b_after_e = begin_edge > end_edge;
	assign lo        = (begin_edge < end_edge) ? begin_edge : end_edge;
	assign hi        = (begin_edge < end_edge) ? end_edge : begin_edge;
	assign dst       = dst_enabled_q && (((gt >= lo) && (gt <= hi)) != b_after_e);
	assign res       = !dst ? base_q[NStg-1] :
		(act_q[NStg-1] ? base_q[NStg-1] - 36'sd3600 : base_q[NStg-1] + 36'sd3600);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[NStg-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_secs_q <= res;
			out_dst_q  <= dst;
			out_obs_q  <= dst_enabled_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign seconds_out  = out_secs_q;
	assign in_dst       = out_dst_q;
	assign dst_observed = out_obs_q;

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> vld_q[0]) else $error("popped item lost at stage one");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q)) else $error("back pipeline moved while stalled");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seconds_out))
		else $error("result item changed while waiting");

endmodule
`default_nettype wire

FILE: test/tb_utc_local_time_with_dst_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_utc_local_time_with_dst_top;
	import utcl_pkg::*;

	localparam longint HOUR = 3600;
	localparam longint DAY  = 86400;
	localparam int     WAIT_LIMIT = 4_000_000;

	typedef struct packed {
		logic signed [35:0] secs;
		logic               dst;
		logic               observed;
	} conversion_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [33:0]        seconds_in;
	logic               out_valid;
	logic               out_ready;
	logic signed [35:0] seconds_out;
	logic               in_dst;
	logic               dst_observed;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [4:0]         cfg_wdata;

	// predictor copy of the registers
	longint zone_hours;
	logic   dst_on;
	longint b_month, b_index, b_hour, e_month, e_index, e_hour;

	conversion_t pending_conversions[$];
	int          error_count;
	int          cycle_count;
	bit          hold_off;
	int          hold_cycles;
	int          stall_left;

	utc_local_time_with_dst_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .seconds_in(seconds_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.seconds_out(seconds_out), .in_dst(in_dst), .dst_observed(dst_observed),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// calendar arithmetic
	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) < 0) q--;
		return q;
	endfunction

	function automatic longint month_start_days(longint y, longint m);
		longint era, yoe, mp, doy;
		if (m <= 2) y -= 1;
		era = fdiv(y, 400);
		yoe = y - era * 400;
		mp  = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5;
		return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
	endfunction

	function automatic longint year_of(longint t);
		longint z, era, doe, yoe, doy, mp, y;
		z   = fdiv(t, DAY) + 719468;
		era = fdiv(z, 146097);
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp  = (5 * doy + 2) / 153;
		y   = yoe + era * 400;
		if (mp >= 10) y += 1;
		return y;
	endfunction

	// nth sunday at hour, k <= 0 counts back from the next month
	function automatic longint sunday_edge(longint year, longint month, longint k, longint hr);
		longint m, y, t, wd;
		m  = (k > 0) ? month : month + 1;
		y  = year + m / 12;
		m  = m % 12;
		t  = month_start_days(y, m + 1) * DAY + hr * HOUR;
		wd = (fdiv(t, DAY) % 7 + 11) % 7;
		t += ((7 - wd) % 7) * DAY;
		t += ((k > 0) ? k - 1 : k) * 7 * DAY;
		return t;
	endfunction

	function automatic logic dst_window_hit(longint g);
		longint y, b, e, lo, hi;
		if (!dst_on) return 1'b0;
		y  = year_of(g);
		b  = sunday_edge(y, b_month, b_index, b_hour);
		e  = sunday_edge(y, e_month, e_index, e_hour);
		lo = (b < e) ? b : e;
		hi = (b < e) ? e : b;
		return (g >= lo && g <= hi) != (b > e);
	endfunction

	function automatic conversion_t convert(logic act, logic [33:0] secs);
		conversion_t c;
		longint s, g, r;
		s = longint'({30'd0, secs});
		if (!act) begin
			c.dst = dst_window_hit(s);
			r = s + zone_hours * HOUR + (c.dst ? HOUR : 0);
		end else begin
			g = s - zone_hours * HOUR;
			c.dst = dst_window_hit(g);
			r = g - (c.dst ? HOUR : 0);
		end
		c.secs     = r[35:0];
		c.observed = dst_on;
		return c;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > WAIT_LIMIT) begin
			$display("utc_local_time_with_dst_top: mismatch");
			$finish;
		end
	end

	// receiver: random ready with short and occasional long stalls, long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles <= 0;
			stall_left <= 0;
		end else if (hold_off) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 3) begin
			out_ready <= 1'b0;
			stall_left <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(8, 40)) : 0;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 1);
		end
	end

	// result checker
	always @(posedge clk) begin
		conversion_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_conversions.size() == 0) begin
				$display("%0t: unexpected item secs=%0d dst=%b", $time, seconds_out, in_dst);
				error_count++;
			end else begin
				want = pending_conversions.pop_front();
				if (seconds_out !== want.secs) begin
					$display("%0t: seconds_out expected %0d actual %0d",
						$time, want.secs, seconds_out);
					error_count++;
				end
				if (in_dst !== want.dst) begin
					$display("%0t: in_dst expected %b actual %b", $time, want.dst, in_dst);
					error_count++;
				end
				if (dst_observed !== want.observed) begin
					$display("%0t: dst_observed expected %b actual %b",
						$time, want.observed, dst_observed);
					error_count++;
				end
			end
		end
	end

	// send one item, with a random gap before it; valid stays up between
	// back-to-back items and drops only for a gap or in drain
	task automatic send_item(logic act, logic [33:0] secs);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		seconds_in <= secs;
		pending_conversions.insert(pending_conversions.size(), convert(act, secs));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [4:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_ZONE_OFFSET: zone_hours = longint'($signed(val));
			REG_DST_ENABLED: dst_on     = val[0];
			REG_BEGIN_MONTH: b_month    = val[3:0];
			REG_BEGIN_INDEX: b_index    = longint'($signed(val[3:0]));
			REG_BEGIN_HOUR:  b_hour     = val;
			REG_END_MONTH:   e_month    = val[3:0];
			REG_END_INDEX:   e_index    = longint'($signed(val[3:0]));
			default:         e_hour     = val;
		endcase
	endtask

	// wait for every result, then the pipeline latency
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_conversions.size() != 0) @(posedge clk);
		repeat (15) @(posedge clk);
	endtask

	task automatic set_rule(int zone, bit en, int bm, int bk, int bh, int em, int ek, int eh);
		write_reg(REG_ZONE_OFFSET, zone[4:0]);
		write_reg(REG_DST_ENABLED, {4'd0, en});
		write_reg(REG_BEGIN_MONTH, bm[4:0]);
		write_reg(REG_BEGIN_INDEX, bk[4:0]);
		write_reg(REG_BEGIN_HOUR,  bh[4:0]);
		write_reg(REG_END_MONTH,   em[4:0]);
		write_reg(REG_END_INDEX,   ek[4:0]);
		write_reg(REG_END_HOUR,    eh[4:0]);
		cfg_we <= 1'b0;
	endtask

	// seconds near a year of interest, biased to the dst edges
	function automatic logic [33:0] pick_seconds();
		longint y, t;
		case ($urandom_range(0, 5))
			0: return 34'({$urandom(), $urandom()});
			1: return 34'($urandom_range(0, 200000));
			2: return 34'h3_FFFF_FFFF - 34'($urandom_range(0, 200000));
			default: begin
				y = $urandom_range(1970, 2400);
				if ($urandom_range(0, 1))
					t = sunday_edge(y, b_month, b_index, b_hour);
				else
					t = sunday_edge(y, e_month, e_index, e_hour);
				t += longint'($urandom_range(0, 4 * HOUR)) - 2 * HOUR
					+ zone_hours * HOUR * $urandom_range(0, 1);
				if (t < 0) t = 0;
				return t[33:0];
			end
		endcase
	endfunction

	// field extremes under reset registers, then under typical, southern and out-of-range rules
	task automatic test_directed;
		longint t;
		send_item(1'b0, 34'd0);
		send_item(1'b1, 34'd0);
		send_item(1'b0, 34'h3_FFFF_FFFF);
		send_item(1'b1, 34'h3_FFFF_FFFF);
		send_item(1'b1, 34'd1000);
		drain();
		// us-style rule: second sunday of march to first sunday of november
		set_rule(-5, 1, 2, 2, 7, 10, 1, 6);
		t = sunday_edge(2024, 2, 2, 7);
		send_item(1'b0, t[33:0]);
		send_item(1'b0, t[33:0] - 34'd1);
		t = sunday_edge(2024, 10, 1, 6);
		send_item(1'b0, t[33:0]);
		send_item(1'b0, t[33:0] + 34'd1);
		send_item(1'b1, 34'd1_720_000_000);
		send_item(1'b1, 34'd10);
		drain();
		// southern rule: begin after end, last sunday counted back
		set_rule(14, 1, 9, 1, 2, 3, 0, 3);
		send_item(1'b0, 34'd1_700_000_000);
		send_item(1'b0, 34'd1_712_000_000);
		t = sunday_edge(2030, 3, 0, 3);
		send_item(1'b1, t[33:0]);
		drain();
		// months and hours out of range, extreme indexes
		set_rule(-12, 1, 15, -8, 31, 12, 7, 24);
		send_item(1'b0, 34'd1_000_000_000);
		send_item(1'b1, 34'd30000);
		send_item(1'b0, 34'h3_FFFF_0000);
		drain();
	endtask

	// random items under a series of random and extreme rules
	task automatic test_random_rules;
		for (int phase = 0; phase < 14; phase++) begin
			if (phase == 0)      set_rule(-12, 1, 0, -5, 0, 11, 5, 23);
			else if (phase == 1) set_rule(14, 0, 11, 5, 23, 0, -5, 0);
			else if (phase == 2) set_rule(-16, 1, 15, 7, 31, 15, -8, 31);
			else set_rule($urandom_range(0, 31), $urandom_range(0, 3) != 0,
				$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 31),
				$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 31));
			for (int i = 0; i < 120; i++) send_item($urandom_range(0, 1), pick_seconds());
			drain();
		end
	endtask

	// receiver stalls for a long time while the sender keeps offering items
	task automatic test_backpressure;
		set_rule(1, 1, 2, -1, 1, 9, 0, 1);
		hold_off = 1'b1;
		fork
			for (int i = 0; i < 60; i++) send_item($urandom_range(0, 1), pick_seconds());
			begin
				wait (hold_cycles >= 200);
				hold_off = 1'b0;
			end
		join
		drain();
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = 1'b0;
		seconds_in  = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		error_count = 0;
		cycle_count = 0;
		hold_off    = 1'b0;
		zone_hours = 8; dst_on = 1'b0;
		b_month = 0; b_index = 0; b_hour = 0;
		e_month = 0; e_index = 0; e_hour = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_rules();
		test_backpressure();
		if (error_count == 0)
			$display("utc_local_time_with_dst_top: match");
		else
			$display("utc_local_time_with_dst_top: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
